@@ rtl/thc_pkg.sv @@
// Package for the temperature and humidity compensation pipeline: codes, constants, helpers.
package thc_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned NumStages = 11;

  typedef enum logic [1:0] {
    REG_TEMP_CALIB = 2'd0,
    REG_HUM_CALIB  = 2'd1,
    REG_HUM_FIRST  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  localparam logic signed [31:0] TEMP_MIN_CENTI  = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX_CENTI  = 32'sd8500;
  localparam logic signed [31:0] TEMP_ROUND      = 32'sd128;
  localparam logic signed [31:0] HUM_OFFSET_FINE = 32'sd76800;
  localparam logic signed [31:0] HUM_CLAMP_HIGH  = 32'sd419430400;
  localparam logic signed [31:0] HUM_BIAS_D      = 32'sd2097152;
  localparam logic signed [31:0] HUM_ROUND_E     = 32'sd16384;
  localparam logic signed [31:0] HUM_ROUND_B     = 32'sd8192;
  localparam logic signed [31:0] HUM_BIAS_C      = 32'sd32768;

  // Signed divide by 2**sh, truncating toward zero.
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                 input int unsigned sh);
    logic signed [31:0] bias;
    bias = x[31] ? $signed((32'd1 << sh) - 32'd1) : 32'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

@@ rtl/temp_humidity_compensation.sv @@
// Temperature and humidity compensation: APB coefficient registers and arithmetic pipeline.
// Data passes through 11 register stages, s0 to s10, from input accept to output.
// Throughput: one item per cycle while not stalled; per-stage valid bits, a stage advances
// when empty or when the next one advances, so a stall loses and repeats nothing.
// Reset: rst_ni (async, active low) clears all valid bits and all coefficient registers.
// Coefficients feed the pipeline directly; users must write them only when idle; unchecked.
module temp_humidity_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [thc_pkg::AddrWidth-1:0]       paddr,
  input  logic [thc_pkg::DataWidth-1:0]       pwdata,
  output logic [thc_pkg::DataWidth-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [19:0]                         raw_temp_i,
  input  logic [15:0]                         raw_hum_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [14:0]                  temp_centideg_o,
  output logic [16:0]                         hum_q10_o
);

  // ---------------- configuration registers ----------------
  logic [47:0] temp_calib_q;
  logic [55:0] hum_calib_q;
  logic [7:0]  hum_first_q;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      hum_calib_q  <= '0;
      hum_first_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        thc_pkg::REG_TEMP_CALIB: temp_calib_q <= pwdata[47:0];
        thc_pkg::REG_HUM_CALIB:  hum_calib_q  <= pwdata[55:0];
        thc_pkg::REG_HUM_FIRST:  hum_first_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      thc_pkg::REG_TEMP_CALIB: prdata = {16'd0, temp_calib_q};
      thc_pkg::REG_HUM_CALIB:  prdata = {8'd0, hum_calib_q};
      thc_pkg::REG_HUM_FIRST:  prdata = {56'd0, hum_first_q};
      default:                 prdata = '0;
    endcase
  end

  // ---------------- coefficient unpacking ----------------
  logic [15:0]        t1;
  logic signed [31:0] t2, t3, h1, h2, h3, h6, hum_c;

  assign t1    = temp_calib_q[15:0];
  assign t2    = 32'(signed'(temp_calib_q[31:16]));
  assign t3    = 32'(signed'(temp_calib_q[47:32]));
  assign h1    = $signed({24'd0, hum_first_q});
  assign h2    = 32'(signed'(hum_calib_q[15:0]));
  assign h3    = $signed({24'd0, hum_calib_q[23:16]});
  assign h6    = 32'(signed'(hum_calib_q[55:48]));
  // H4 * 2^20, wrapped to 32 bits
  assign hum_c = $signed({hum_calib_q[31:24], hum_calib_q[35:32], 20'd0});

  logic signed [31:0] h5;
  assign h5 = 32'(signed'({hum_calib_q[47:40], hum_calib_q[39:36]}));

  // ---------------- stage handshake ----------------
  logic [thc_pkg::NumStages-1:0] v_q;
  logic [thc_pkg::NumStages:0]   en;

  always_comb begin
    en[thc_pkg::NumStages] = out_ready_i;
    for (int i = thc_pkg::NumStages - 1; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[thc_pkg::NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < thc_pkg::NumStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // ---------------- stage 0: differences ----------------
  logic signed [31:0] s0_a_q, s0_b_q;
  logic [15:0]        s0_rh_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_a_q  <= $signed({15'd0, raw_temp_i[19:3]}) - $signed({15'd0, t1, 1'b0});
      s0_b_q  <= $signed({16'd0, raw_temp_i[19:4]}) - $signed({16'd0, t1});
      s0_rh_q <= raw_hum_i;
    end
  end

  // ---------------- stage 1: a*T2, b*b ----------------
  logic signed [31:0] s1_pa_q, s1_pbb_q;
  logic [15:0]        s1_rh_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_pa_q  <= s0_a_q * t2;
      s1_pbb_q <= s0_b_q * s0_b_q;
      s1_rh_q  <= s0_rh_q;
    end
  end

  // ---------------- stage 2: scale, times T3 ----------------
  logic signed [31:0] s2_a_q, s2_pb3_q;
  logic [15:0]        s2_rh_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_a_q   <= thc_pkg::sdiv_p2(s1_pa_q, 11);
      s2_pb3_q <= thc_pkg::sdiv_p2(s1_pbb_q, 12) * t3;
      s2_rh_q  <= s1_rh_q;
    end
  end

  // ---------------- stage 3: fine temperature ----------------
  logic signed [31:0] s3_fine_q;
  logic [15:0]        s3_rh_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_fine_q <= s2_a_q + thc_pkg::sdiv_p2(s2_pb3_q, 14);
      s3_rh_q   <= s2_rh_q;
    end
  end

  // ---------------- stage 4: temperature, humidity products ----------------
  logic signed [31:0] tt, adiff;
  logic signed [14:0] t_sat;
  logic signed [31:0] s4_d5_q, s4_b6_q, s4_c3_q;
  logic signed [14:0] s4_t_q;
  logic [15:0]        s4_rh_q;

  always_comb begin
    tt    = thc_pkg::sdiv_p2(s3_fine_q * 32'sd5 + thc_pkg::TEMP_ROUND, 8);
    adiff = s3_fine_q - thc_pkg::HUM_OFFSET_FINE;
    if (tt < thc_pkg::TEMP_MIN_CENTI) begin
      t_sat = thc_pkg::TEMP_MIN_CENTI[14:0];
    end else if (tt > thc_pkg::TEMP_MAX_CENTI) begin
      t_sat = thc_pkg::TEMP_MAX_CENTI[14:0];
    end else begin
      t_sat = tt[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_t_q  <= t_sat;
      s4_d5_q <= h5 * adiff;
      s4_b6_q <= adiff * h6;
      s4_c3_q <= adiff * h3;
      s4_rh_q <= s3_rh_q;
    end
  end

  // ---------------- stage 5: e term, first humidity product ----------------
  logic signed [31:0] hum_b, e5, bq5, cq5;
  logic signed [31:0] s5_e_q, s5_m_q;
  logic signed [14:0] s5_t_q;

  always_comb begin
    hum_b = $signed({2'd0, s4_rh_q, 14'd0});
    e5    = thc_pkg::sdiv_p2(hum_b - hum_c - s4_d5_q + thc_pkg::HUM_ROUND_E, 15);
    bq5   = thc_pkg::sdiv_p2(s4_b6_q, 10);
    cq5   = thc_pkg::sdiv_p2(s4_c3_q, 11);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_e_q <= e5;
      s5_m_q <= bq5 * (cq5 + thc_pkg::HUM_BIAS_C);
      s5_t_q <= s4_t_q;
    end
  end

  // ---------------- stage 6: times H2 ----------------
  logic signed [31:0] s6_p_q, s6_e_q;
  logic signed [14:0] s6_t_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_p_q <= (thc_pkg::sdiv_p2(s5_m_q, 10) + thc_pkg::HUM_BIAS_D) * h2;
      s6_e_q <= s5_e_q;
      s6_t_q <= s5_t_q;
    end
  end

  // ---------------- stage 7: c = e * b ----------------
  logic signed [31:0] s7_c_q;
  logic signed [14:0] s7_t_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_c_q <= s6_e_q * thc_pkg::sdiv_p2(s6_p_q + thc_pkg::HUM_ROUND_B, 14);
      s7_t_q <= s6_t_q;
    end
  end

  // ---------------- stage 8: square ----------------
  logic signed [31:0] q8;
  logic signed [31:0] s8_sq_q, s8_c_q;
  logic signed [14:0] s8_t_q;

  assign q8 = thc_pkg::sdiv_p2(s7_c_q, 15);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_sq_q <= q8 * q8;
      s8_c_q  <= s7_c_q;
      s8_t_q  <= s7_t_q;
    end
  end

  // ---------------- stage 9: times H1 ----------------
  logic signed [31:0] s9_r_q, s9_c_q;
  logic signed [14:0] s9_t_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_r_q <= thc_pkg::sdiv_p2(s8_sq_q, 7) * h1;
      s9_c_q <= s8_c_q;
      s9_t_q <= s8_t_q;
    end
  end

  // ---------------- stage 10: humidity saturation, output register ----------------
  logic signed [31:0] e10;
  logic [16:0]        h_sat;
  logic [16:0]        s10_h_q;
  logic signed [14:0] s10_t_q;

  always_comb begin
    e10 = s9_c_q - thc_pkg::sdiv_p2(s9_r_q, 4);
    if (e10 < 32'sd0) begin
      h_sat = '0;
    end else if (e10 > thc_pkg::HUM_CLAMP_HIGH) begin
      h_sat = thc_pkg::HUM_CLAMP_HIGH[28:12];
    end else begin
      h_sat = e10[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_h_q <= h_sat;
      s10_t_q <= s9_t_q;
    end
  end

  assign temp_centideg_o = s10_t_q;
  assign hum_q10_o       = s10_h_q;

  // ---------------- assertions ----------------
  a_block_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("input blocked while pipeline has room");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temp_centideg_o >= -15'sd4000) && (temp_centideg_o <= 15'sd8500))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hum_q10_o <= 17'd102400)
    else $error("humidity out of range");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(temp_centideg_o) && $stable(hum_q10_o))
    else $error("stalled result changed");

endmodule
